[rtl/ffba_pkg.sv]
`timescale 1ns / 1ps

package ffba_pkg;

  // Fixed payload widths of the request and result channels
  localparam int unsigned ADDR_W      = 48;
  localparam int unsigned SIZE_W      = 24;
  localparam int unsigned ST_W        = 3;
  localparam int unsigned PAGES_W     = 9;
  localparam int unsigned TOT_W       = 21;
  localparam int unsigned CNT_OUT_W   = 6;
  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned IN_TUSER_W  = 1;
  localparam int unsigned OUT_USED_W  = ST_W + ADDR_W + PAGES_W + 2 * TOT_W + 2 * CNT_OUT_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

  // Width of the shared divider dividend and of products built from it
  localparam int unsigned Q_W = 32;

  typedef logic [ST_W-1:0] status_t;

  localparam status_t ST_OK          = 3'd0;
  localparam status_t ST_NULL_ADDR   = 3'd1;
  localparam status_t ST_ZERO_SIZE   = 3'd2;
  localparam status_t ST_TOO_LARGE   = 3'd3;
  localparam status_t ST_NO_MEM      = 3'd4;
  localparam status_t ST_NO_BLOCKS   = 3'd5;
  localparam status_t ST_BAD_PTR     = 3'd6;
  localparam status_t ST_DOUBLE_FREE = 3'd7;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[rtl/first_fit_block_table_allocator.sv]
// First-fit heap allocator over an ordered block table.
//
// Request channel (in_*): one request per handshake. in_tuser selects
// allocate or free, in_tdata carries the size and the address to free.
// Result channel (out_*): exactly one result per request, in order.
// Config channel (cfg_*): writes window_base; always ready, write only
// while no request is in flight.
//
// A free scans the table for its entry and moves entries down when
// neighbors merge. An allocate scans for the first free entry that fits,
// grows the heap through the divider when none fits, and moves entries
// up for a split. The worst case is a free near the table start that
// merges on both sides. The single table RAM with registered read and
// the reciprocal-multiply rounding unit set the pace. One request at a
// time; in_tready is high only between requests.
//
// Reset: table empty, counters zero, window_base back to 0x1_0000_0000.
// Table RAM is not cleared; only entries below the count are read.
// A stalled receiver leaves the result in the output register; the next
// request is taken and worked on, and only its final load waits.
`timescale 1ns / 1ps

module first_fit_block_table_allocator #(
  parameter int unsigned MAX_BLOCKS   = 32,
  parameter int unsigned ALLOC_UNIT   = 16,
  parameter int unsigned PAGE_BYTES   = 4096,
  parameter int unsigned WINDOW_BYTES = 1048576
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [23:0] req_size, [71:24] req_address
  input  logic [ffba_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [0] req_type
  input  logic [ffba_pkg::IN_TUSER_W-1:0]   in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [2:0] status, [50:3] block_address, [59:51] pages_committed,
  // [80:60] committed_total, [101:81] allocated_total,
  // [107:102] live_total, [113:108] entries_in_use, rest zero
  output logic [ffba_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ffba_pkg::ADDR_W-1:0]       cfg_data
);
  import ffba_pkg::*;

  localparam int unsigned OFF_W = $clog2(WINDOW_BYTES);
  localparam int unsigned LEN_W = OFF_W + 1;
  localparam int unsigned AW    = $clog2(MAX_BLOCKS);
  localparam int unsigned CW    = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned DVS_W =
    $clog2(((ALLOC_UNIT > PAGE_BYTES) ? ALLOC_UNIT : PAGE_BYTES) + 1);
  localparam int unsigned PAD_W = OUT_TDATA_W - OUT_USED_W;

  localparam logic [ADDR_W-1:0] BASE_RST = 48'h0001_0000_0000;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_ACHK  = 5'd1;
  localparam logic [4:0] S_DIV   = 5'd2;
  localparam logic [4:0] S_MUL   = 5'd3;
  localparam logic [4:0] S_NEED  = 5'd4;
  localparam logic [4:0] S_SRD   = 5'd5;
  localparam logic [4:0] S_SCK   = 5'd6;
  localparam logic [4:0] S_GROW  = 5'd7;
  localparam logic [4:0] S_GCHK  = 5'd8;
  localparam logic [4:0] S_SPLIT = 5'd9;
  localparam logic [4:0] S_SHRD  = 5'd10;
  localparam logic [4:0] S_SHWR  = 5'd11;
  localparam logic [4:0] S_SPWR  = 5'd12;
  localparam logic [4:0] S_FCHK  = 5'd13;
  localparam logic [4:0] S_FFND  = 5'd14;
  localparam logic [4:0] S_NRD   = 5'd15;
  localparam logic [4:0] S_NCK   = 5'd16;
  localparam logic [4:0] S_PRD   = 5'd17;
  localparam logic [4:0] S_PCK   = 5'd18;
  localparam logic [4:0] S_DRRD  = 5'd19;
  localparam logic [4:0] S_DRWR  = 5'd20;
  localparam logic [4:0] S_DONE  = 5'd21;

  typedef struct packed {
    logic             busy;
    logic [LEN_W-1:0] len;
    logic [OFF_W-1:0] off;
  } ent_t;

  // control
  logic [4:0]        state_r, state_nxt;
  logic [4:0]        ret_r, ret_nxt;
  logic              phase_r, phase_nxt;   // 0: rounding size, 1: growth
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     ptr_r, ptr_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [LEN_W-1:0]  committed_r, committed_nxt;
  logic [LEN_W-1:0]  allocated_r, allocated_nxt;
  logic [CW-1:0]     live_r, live_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic              out_valid_r, out_valid_nxt;

  // payload
  logic                   type_r, type_nxt;
  logic [SIZE_W-1:0]      size_r, size_nxt;
  logic [ADDR_W-1:0]      faddr_r, faddr_nxt;
  logic [OFF_W-1:0]       foff_r, foff_nxt;
  logic [LEN_W-1:0]       need_r, need_nxt;
  logic [Q_W-1:0]         prod_r, prod_nxt;
  logic [PAGES_W-1:0]     pages_r, pages_nxt;
  status_t                status_r, status_nxt;
  logic [ADDR_W-1:0]      baddr_r, baddr_nxt;
  ent_t                   ent_r, ent_nxt;
  ent_t                   last_r, last_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  // table RAM
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  ent_t          ram_wdata;
  logic [AW-1:0] ram_raddr;
  ent_t          rdata;

  // divider
  logic           div_start;
  logic           div_sel_b;   // 1: divide by PAGE_BYTES
  logic [Q_W-1:0] div_dvd;
  logic [Q_W-1:0] div_q;
  div_stat_t      div_st;

  // helpers
  logic [CW-1:0]     idx_p1, idx_m1, ptr_p1, ptr_m1, cnt_m1;
  logic              extend;
  logic [LEN_W-1:0]  trailing;
  logic [LEN_W-1:0]  rem;
  logic [Q_W-1:0]    avail;
  logic [ADDR_W-1:0] fdiff;
  logic [ADDR_W:0]   win_end;
  logic [DVS_W-1:0]  mul_k;

  assign idx_p1   = idx_r + CW'(1);
  assign idx_m1   = idx_r - CW'(1);
  assign ptr_p1   = ptr_r + CW'(1);
  assign ptr_m1   = ptr_r - CW'(1);
  assign cnt_m1   = count_r - CW'(1);
  assign extend   = (count_r != '0) && !last_r.busy;
  assign trailing = extend ? last_r.len : '0;
  assign rem      = ent_r.len - need_r;
  assign avail    = Q_W'(WINDOW_BYTES) - Q_W'(committed_r);
  assign fdiff    = faddr_r - base_r;
  assign win_end  = {1'b0, base_r} + (ADDR_W + 1)'(committed_r);
  assign mul_k    = phase_r ? DVS_W'(PAGE_BYTES) : DVS_W'(ALLOC_UNIT);

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    phase_nxt     = phase_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    idx_nxt       = idx_r;
    committed_nxt = committed_r;
    allocated_nxt = allocated_r;
    live_nxt      = live_r;
    base_nxt      = base_r;
    out_valid_nxt = out_valid_r;
    type_nxt      = type_r;
    size_nxt      = size_r;
    faddr_nxt     = faddr_r;
    foff_nxt      = foff_r;
    need_nxt      = need_r;
    prod_nxt      = prod_r;
    pages_nxt     = pages_r;
    status_nxt    = status_r;
    baddr_nxt     = baddr_r;
    ent_nxt       = ent_r;
    last_nxt      = last_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = idx_r[AW-1:0];
    ram_wdata     = ent_r;
    ram_raddr     = ptr_r[AW-1:0];
    div_start     = 1'b0;
    div_sel_b     = 1'b0;
    div_dvd       = Q_W'(size_r) + Q_W'(ALLOC_UNIT - 1);

    if (cfg_valid) begin
      base_nxt = cfg_data;
    end
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          type_nxt   = in_tuser[0];
          size_nxt   = in_tdata[SIZE_W-1:0];
          faddr_nxt  = in_tdata[SIZE_W +: ADDR_W];
          pages_nxt  = '0;
          baddr_nxt  = '0;
          status_nxt = ST_OK;
          state_nxt  = (in_tuser[0] == REQ_FREE) ? S_FCHK : S_ACHK;
        end
      end
      S_ACHK: begin
        if (size_r == '0) begin
          status_nxt = ST_ZERO_SIZE;
          state_nxt  = S_DONE;
        end else if (Q_W'(size_r) > Q_W'(WINDOW_BYTES)) begin
          status_nxt = ST_TOO_LARGE;
          state_nxt  = S_DONE;
        end else begin
          div_start = 1'b1;
          phase_nxt = 1'b0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_st.done) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt  = Q_W'(div_q * mul_k);
        state_nxt = phase_r ? S_GCHK : S_NEED;
      end
      S_NEED: begin
        if (prod_r > Q_W'(WINDOW_BYTES)) begin
          status_nxt = ST_TOO_LARGE;
          state_nxt  = S_DONE;
        end else begin
          need_nxt  = LEN_W'(prod_r);
          ptr_nxt   = '0;
          state_nxt = S_SRD;
        end
      end
      S_SRD: begin
        if (ptr_r == count_r) begin
          if (type_r == REQ_FREE) begin
            status_nxt = ST_BAD_PTR;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_GROW;
          end
        end else begin
          state_nxt = S_SCK;
        end
      end
      S_SCK: begin
        if (type_r == REQ_ALLOC) begin
          if (!rdata.busy && rdata.len >= need_r) begin
            idx_nxt   = ptr_r;
            ent_nxt   = rdata;
            state_nxt = S_SPLIT;
          end else begin
            last_nxt  = rdata;
            ptr_nxt   = ptr_p1;
            state_nxt = S_SRD;
          end
        end else begin
          if (rdata.off == foff_r) begin
            idx_nxt = ptr_r;
            ent_nxt = rdata;
            if (!rdata.busy) begin
              status_nxt = ST_DOUBLE_FREE;
              state_nxt  = S_DONE;
            end else begin
              state_nxt = S_FFND;
            end
          end else begin
            ptr_nxt   = ptr_p1;
            state_nxt = S_SRD;
          end
        end
      end
      S_GROW: begin
        div_start = 1'b1;
        div_sel_b = 1'b1;
        div_dvd   = Q_W'(need_r) - Q_W'(trailing) + Q_W'(PAGE_BYTES - 1);
        phase_nxt = 1'b1;
        state_nxt = S_DIV;
      end
      S_GCHK: begin
        if (prod_r > avail) begin
          status_nxt = ST_NO_MEM;
          state_nxt  = S_DONE;
        end else if (!extend && count_r >= CW'(MAX_BLOCKS)) begin
          status_nxt = ST_NO_BLOCKS;
          state_nxt  = S_DONE;
        end else begin
          ram_we = 1'b1;
          if (extend) begin
            ent_nxt.busy = 1'b0;
            ent_nxt.off  = last_r.off;
            ent_nxt.len  = last_r.len + LEN_W'(prod_r);
            idx_nxt      = cnt_m1;
            ram_waddr    = cnt_m1[AW-1:0];
          end else begin
            ent_nxt.busy = 1'b0;
            ent_nxt.off  = OFF_W'(committed_r);
            ent_nxt.len  = LEN_W'(prod_r);
            idx_nxt      = count_r;
            ram_waddr    = count_r[AW-1:0];
            count_nxt    = count_r + CW'(1);
          end
          ram_wdata     = ent_nxt;
          committed_nxt = committed_r + LEN_W'(prod_r);
          pages_nxt     = PAGES_W'(div_q);
          state_nxt     = S_SPLIT;
        end
      end
      S_SPLIT: begin
        if (rem >= LEN_W'(ALLOC_UNIT)) begin
          if (count_r >= CW'(MAX_BLOCKS)) begin
            status_nxt = ST_NO_BLOCKS;
            state_nxt  = S_DONE;
          end else begin
            ptr_nxt   = count_r;
            state_nxt = S_SHRD;
          end
        end else begin
          ram_we        = 1'b1;
          ram_wdata     = '{busy: 1'b1, len: ent_r.len, off: ent_r.off};
          allocated_nxt = allocated_r + ent_r.len;
          live_nxt      = live_r + CW'(1);
          baddr_nxt     = base_r + ADDR_W'(ent_r.off);
          status_nxt    = ST_OK;
          state_nxt     = S_DONE;
        end
      end
      // open a slot at idx+1 by moving entries up, top first
      S_SHRD: begin
        if (ptr_r > idx_p1) begin
          ram_raddr = ptr_m1[AW-1:0];
          state_nxt = S_SHWR;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = idx_p1[AW-1:0];
          ram_wdata = '{busy: 1'b0, len: rem, off: ent_r.off + OFF_W'(need_r)};
          state_nxt = S_SPWR;
        end
      end
      S_SHWR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_r[AW-1:0];
        ram_wdata = rdata;
        ptr_nxt   = ptr_m1;
        state_nxt = S_SHRD;
      end
      S_SPWR: begin
        ram_we        = 1'b1;
        ram_wdata     = '{busy: 1'b1, len: need_r, off: ent_r.off};
        count_nxt     = count_r + CW'(1);
        allocated_nxt = allocated_r + need_r;
        live_nxt      = live_r + CW'(1);
        baddr_nxt     = base_r + ADDR_W'(ent_r.off);
        status_nxt    = ST_OK;
        state_nxt     = S_DONE;
      end
      S_FCHK: begin
        if (faddr_r == '0) begin
          status_nxt = ST_NULL_ADDR;
          state_nxt  = S_DONE;
        end else if (faddr_r < base_r || {1'b0, faddr_r} >= win_end) begin
          status_nxt = ST_BAD_PTR;
          state_nxt  = S_DONE;
        end else begin
          foff_nxt  = fdiff[OFF_W-1:0];
          ptr_nxt   = '0;
          state_nxt = S_SRD;
        end
      end
      S_FFND: begin
        allocated_nxt = allocated_r - ent_r.len;
        live_nxt      = live_r - CW'(1);
        ent_nxt.busy  = 1'b0;
        status_nxt    = ST_OK;
        state_nxt     = S_NRD;
      end
      // merge with the following block
      S_NRD: begin
        if (idx_p1 < count_r) begin
          ram_raddr = idx_p1[AW-1:0];
          state_nxt = S_NCK;
        end else begin
          state_nxt = S_PRD;
        end
      end
      S_NCK: begin
        if (!rdata.busy) begin
          ent_nxt.len = ent_r.len + rdata.len;
          ptr_nxt     = idx_p1;
          ret_nxt     = S_PRD;
          state_nxt   = S_DRRD;
        end else begin
          state_nxt = S_PRD;
        end
      end
      // merge into the preceding block
      S_PRD: begin
        if (idx_r != '0) begin
          ram_raddr = idx_m1[AW-1:0];
          state_nxt = S_PCK;
        end else begin
          ram_we    = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_PCK: begin
        ram_we = 1'b1;
        if (!rdata.busy) begin
          ram_waddr = idx_m1[AW-1:0];
          ram_wdata = '{busy: 1'b0, len: rdata.len + ent_r.len, off: rdata.off};
          ptr_nxt   = idx_r;
          ret_nxt   = S_DONE;
          state_nxt = S_DRRD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      // remove entry ptr by moving the rest down
      S_DRRD: begin
        if (ptr_p1 < count_r) begin
          ram_raddr = ptr_p1[AW-1:0];
          state_nxt = S_DRWR;
        end else begin
          count_nxt = cnt_m1;
          state_nxt = ret_r;
        end
      end
      S_DRWR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_r[AW-1:0];
        ram_wdata = rdata;
        ptr_nxt   = ptr_p1;
        state_nxt = S_DRRD;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {{PAD_W{1'b0}},
                           CNT_OUT_W'(count_r),
                           CNT_OUT_W'(live_r),
                           TOT_W'(allocated_r),
                           TOT_W'(committed_r),
                           pages_r,
                           baddr_r,
                           status_r};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_DONE;
      phase_r     <= 1'b0;
      count_r     <= '0;
      ptr_r       <= '0;
      idx_r       <= '0;
      committed_r <= '0;
      allocated_r <= '0;
      live_r      <= '0;
      base_r      <= BASE_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      phase_r     <= phase_nxt;
      count_r     <= count_nxt;
      ptr_r       <= ptr_nxt;
      idx_r       <= idx_nxt;
      committed_r <= committed_nxt;
      allocated_r <= allocated_nxt;
      live_r      <= live_nxt;
      base_r      <= base_nxt;
      out_valid_r <= out_valid_nxt;
    end
    type_r     <= type_nxt;
    size_r     <= size_nxt;
    faddr_r    <= faddr_nxt;
    foff_r     <= foff_nxt;
    need_r     <= need_nxt;
    prod_r     <= prod_nxt;
    pages_r    <= pages_nxt;
    status_r   <= status_nxt;
    baddr_r    <= baddr_nxt;
    ent_r      <= ent_nxt;
    last_r     <= last_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  ffba_ram #(
    .WIDTH ($bits(ent_t)),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  ffba_div #(
    .DVD_W (Q_W),
    .DIV_A (ALLOC_UNIT),
    .DIV_B (PAGE_BYTES)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .sel_b    (div_sel_b),
    .dividend (div_dvd),
    .quotient (div_q),
    .stat     (div_st)
  );

  a_live_le_count: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= count_r)
    else $error("more used blocks than table entries");

  a_alloc_le_commit: assert property (@(posedge clk) disable iff (!rst_n)
    allocated_r <= committed_r)
    else $error("allocated bytes exceed committed bytes");

  a_commit_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    committed_r <= LEN_W'(WINDOW_BYTES))
    else $error("committed bytes beyond window");

  a_count_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_BLOCKS))
    else $error("table count beyond capacity");

  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request taken while another is in progress");

endmodule

[rtl/ffba_ram.sv]
`timescale 1ns / 1ps

module ffba_ram #(
  parameter int unsigned WIDTH = 42,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/ffba_div.sv]
`timescale 1ns / 1ps

// Divider by one of two constants, done by reciprocal multiplication.
// start registers the dividend, then the quotient; sel_b picks DIV_B.
module ffba_div #(
  parameter int unsigned DVD_W = 32,
  parameter int unsigned DIV_A = 16,
  parameter int unsigned DIV_B = 4096
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic                     sel_b,
  input  logic [DVD_W-1:0]         dividend,
  output logic [DVD_W-1:0]         quotient,
  output ffba_pkg::div_stat_t      stat
);
  import ffba_pkg::*;

  // m = ceil(2^s / d) with s = DVD_W + ceil(log2 d) is exact for every
  // dividend below 2^DVD_W
  localparam int unsigned SH_A = DVD_W + $clog2(DIV_A);
  localparam int unsigned SH_B = DVD_W + $clog2(DIV_B);
  localparam int unsigned M_W  = DVD_W + 2;
  localparam int unsigned P_W  = DVD_W + M_W;
  localparam logic [63:0] M_A64 = ((64'd1 << SH_A) + 64'(DIV_A - 1)) / 64'(DIV_A);
  localparam logic [63:0] M_B64 = ((64'd1 << SH_B) + 64'(DIV_B - 1)) / 64'(DIV_B);
  localparam logic [M_W-1:0] M_A = M_A64[M_W-1:0];
  localparam logic [M_W-1:0] M_B = M_B64[M_W-1:0];

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic             sel_r, sel_nxt;
  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [M_W-1:0]   recip;
  logic [P_W-1:0]   prod;

  assign recip = sel_r ? M_B : M_A;
  assign prod  = {{M_W{1'b0}}, dvd_r} * {{DVD_W{1'b0}}, recip};

  always_comb begin
    busy_nxt = 1'b0;
    done_nxt = 1'b0;
    sel_nxt  = sel_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      sel_nxt  = sel_b;
      dvd_nxt  = dividend;
    end else if (busy_r) begin
      quo_nxt  = sel_r ? DVD_W'(prod >> SH_B) : DVD_W'(prod >> SH_A);
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    sel_r <= sel_nxt;
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

[bench/first_fit_block_table_allocator_test.sv]
`timescale 1ns / 1ps

module first_fit_block_table_allocator_test;
  import ffba_pkg::*;

  localparam int unsigned NBLK = 32;
  localparam int unsigned UNIT = 16;
  localparam int unsigned PAGE = 4096;
  localparam int unsigned WIN  = 1048576;
  localparam int unsigned STALL_LIMIT = 20000;

  // last field sits in the lowest bits
  typedef struct packed {
    logic [5:0]   entries;
    logic [5:0]   live;
    logic [20:0]  allocated;
    logic [20:0]  committed;
    logic [8:0]   pages;
    logic [47:0]  addr;
    status_t      status;
  } alloc_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [IN_TUSER_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ADDR_W-1:0] cfg_data = '0;

  first_fit_block_table_allocator dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow heap state
  logic [47:0] base_addr;
  logic [19:0] blk_off [NBLK];
  logic [20:0] blk_len [NBLK];
  logic        blk_busy [NBLK];
  int unsigned blk_count;
  logic [20:0] heap_committed;

  alloc_result_t pending_results[$];
  logic [47:0]   live_addrs[$];
  int errors = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;      // no idling in the final part of the run

  function automatic logic [20:0] round_to(logic [24:0] v, int unsigned unit);
    return 21'(((v + unit - 1) / unit) * unit);
  endfunction

  function automatic void heap_reset();
    base_addr = 48'h1_0000_0000;
    blk_count = 0;
    heap_committed = '0;
  endfunction

  function automatic void drop_blk(int unsigned idx);
    for (int unsigned p = idx; p + 1 < blk_count; p++) begin
      blk_off[p] = blk_off[p+1];
      blk_len[p] = blk_len[p+1];
      blk_busy[p] = blk_busy[p+1];
    end
    blk_count--;
  endfunction

  function automatic status_t heap_alloc(logic [23:0] size, output logic [47:0] addr,
                                         output logic [8:0] pages);
    logic [20:0] need, rem, trailing;
    logic [21:0] growth;
    int unsigned idx;
    bit found, extend;
    idx = 0;
    found = 0;
    addr = '0;
    pages = '0;
    if (size == 0) return ST_ZERO_SIZE;
    if (size > WIN) return ST_TOO_LARGE;
    need = round_to(size, UNIT);
    for (int unsigned p = 0; p < blk_count; p++)
      if (!found && !blk_busy[p] && blk_len[p] >= need) begin
        idx = p;
        found = 1;
      end
    if (!found) begin
      extend = blk_count > 0 && !blk_busy[blk_count-1];
      trailing = extend ? blk_len[blk_count-1] : '0;
      growth = 22'(round_to(25'(need - trailing), PAGE));
      if (growth > WIN - heap_committed) return ST_NO_MEM;
      if (!extend && blk_count >= NBLK) return ST_NO_BLOCKS;
      if (extend) blk_len[blk_count-1] += 21'(growth);
      else begin
        blk_off[blk_count] = 20'(heap_committed);
        blk_len[blk_count] = 21'(growth);
        blk_busy[blk_count] = 1'b0;
        blk_count++;
      end
      heap_committed += 21'(growth);
      pages = 9'(growth / PAGE);
      idx = blk_count - 1;
    end
    rem = blk_len[idx] - need;
    if (rem >= UNIT) begin
      if (blk_count >= NBLK) return ST_NO_BLOCKS;
      for (int unsigned p = blk_count; p > idx + 1; p--) begin
        blk_off[p] = blk_off[p-1];
        blk_len[p] = blk_len[p-1];
        blk_busy[p] = blk_busy[p-1];
      end
      blk_off[idx+1] = blk_off[idx] + 20'(need);
      blk_len[idx+1] = rem;
      blk_busy[idx+1] = 1'b0;
      blk_len[idx] = need;
      blk_count++;
    end
    blk_busy[idx] = 1'b1;
    addr = base_addr + 48'(blk_off[idx]);
    return ST_OK;
  endfunction

  function automatic status_t free_block(logic [47:0] address);
    logic [49:0] off;
    int unsigned idx;
    bit found;
    idx = 0;
    found = 0;
    if (address == 0) return ST_NULL_ADDR;
    // window end may pass 2^48, so compare wide
    if (address < base_addr || 50'(address) >= 50'(base_addr) + 50'(heap_committed))
      return ST_BAD_PTR;
    off = 50'(address - base_addr);
    for (int unsigned p = 0; p < blk_count; p++)
      if (!found && 50'(blk_off[p]) == off) begin
        idx = p;
        found = 1;
      end
    if (!found) return ST_BAD_PTR;
    if (!blk_busy[idx]) return ST_DOUBLE_FREE;
    blk_busy[idx] = 1'b0;
    if (idx + 1 < blk_count && !blk_busy[idx+1]) begin
      blk_len[idx] += blk_len[idx+1];
      drop_blk(idx + 1);
    end
    if (idx > 0 && !blk_busy[idx-1]) begin
      blk_len[idx-1] += blk_len[idx];
      drop_blk(idx);
    end
    return ST_OK;
  endfunction

  function automatic alloc_result_t heap_step(logic kind, logic [23:0] size,
                                              logic [47:0] address);
    alloc_result_t r;
    logic [47:0] a;
    logic [8:0] pg;
    a = '0;
    pg = '0;
    if (kind == REQ_ALLOC) r.status = heap_alloc(size, a, pg);
    else r.status = free_block(address);
    r.addr = (r.status == ST_OK) ? a : '0;
    r.pages = pg;
    r.committed = heap_committed;
    r.allocated = '0;
    r.live = '0;
    for (int unsigned p = 0; p < blk_count; p++)
      if (blk_busy[p]) begin
        r.allocated += blk_len[p];
        r.live++;
      end
    r.entries = 6'(blk_count);
    return r;
  endfunction

  // Send one request; the expectation is queued at acceptance.
  task automatic send_request(logic kind, logic [23:0] size, logic [47:0] address);
    alloc_result_t r;
    @(negedge clk);
    if (!calm && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 14)) @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {address, size};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = heap_step(kind, size, address);
    pending_results.push_back(r);
    if (kind == REQ_ALLOC && r.status == ST_OK) live_addrs.push_back(r.addr);
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(negedge clk);
    // a request may still be finishing its final load
    repeat (200) @(negedge clk);
  endtask

  task automatic write_base(logic [47:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    base_addr = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic alloc(logic [23:0] size);
    send_request(REQ_ALLOC, size, 48'($urandom()) ^ {24'($urandom()), 24'h0});
  endtask

  task automatic free_addr(logic [47:0] a);
    send_request(REQ_FREE, 24'($urandom()), a);
  endtask

  // free a random live block (falls back to junk if none)
  task automatic free_live();
    int unsigned k;
    logic [47:0] a;
    if (live_addrs.size() == 0) begin
      free_addr(base_addr);
      return;
    end
    k = $urandom_range(0, live_addrs.size() - 1);
    a = live_addrs[k];
    live_addrs.delete(k);
    free_addr(a);
  endtask

  // free everything still live so the heap collapses back
  task automatic release_all();
    while (live_addrs.size() != 0) free_live();
  endtask

  task automatic random_size(output logic [23:0] s);
    case ($urandom_range(0, 9))
      0: s = 24'($urandom());
      1: s = 24'($urandom_range(0, 16));
      2, 3: s = 24'($urandom_range(1, 8192));
      4: s = 24'($urandom_range(WIN - 70000, WIN + 16));
      default: s = 24'($urandom_range(1, 600));
    endcase
  endtask

  task automatic test_directed();
    alloc(24'd0);
    alloc(24'hFF_FFFF);
    alloc(24'(WIN + 1));
    alloc(24'd1);
    alloc(24'd16);
    alloc(24'd17);
    alloc(24'd4000);
    free_addr(48'd0);
    free_addr(base_addr - 1);
    free_addr(base_addr + 48'(heap_committed));
    free_addr(base_addr + 48'd8);          // interior
    free_addr(base_addr + 48'd16);
    free_addr(base_addr + 48'd16);         // double free
    free_addr(48'hFFFF_FFFF_FFFF);
    release_all();
    alloc(24'(WIN));                       // whole window
    alloc(24'd1);                          // out of memory
    release_all();
    alloc(24'(WIN - 15));
    release_all();
  endtask

  // fill the table with small blocks to hit both table-full paths
  task automatic test_table_full();
    for (int i = 0; i < 36; i++) alloc(24'($urandom_range(1, 48)));
    free_live();
    free_live();
    alloc(24'd5000);
    alloc(24'd1);
    release_all();
  endtask

  task automatic test_random(int n);
    logic [23:0] s;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: free_addr({$urandom(), 16'($urandom())});
        1: free_addr(base_addr + 48'($urandom_range(0, 4096)));
        2, 3, 4: free_live();
        default: begin
          random_size(s);
          alloc(s);
        end
      endcase
      if (live_addrs.size() > 40) release_all();
    end
  endtask

  task automatic test_base_settings();
    release_all();
    write_base(48'h0);
    alloc(24'd32);
    alloc(24'd64);
    free_addr(48'd0);                      // null, even though a block is there
    test_random(40);
    release_all();
    write_base(48'hFFFF_FFFF_FFFF);        // top of range, addresses wrap
    test_random(40);
    release_all();
    write_base(48'h0000_1234_5677);        // unaligned
    test_random(40);
    release_all();
    write_base(48'($urandom()) << 12);
  endtask

  // Result checker
  always @(posedge clk) begin
    alloc_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = alloc_result_t'(out_tdata[$bits(alloc_result_t)-1:0]);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status)
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        if (got.addr !== want.addr)
          $display("%0t: block_address expected %h actual %h", $time, want.addr, got.addr);
        if (got.pages !== want.pages)
          $display("%0t: pages expected %0d actual %0d", $time, want.pages, got.pages);
        if (got.committed !== want.committed)
          $display("%0t: committed expected %0d actual %0d", $time, want.committed,
                   got.committed);
        if (got.allocated !== want.allocated)
          $display("%0t: allocated expected %0d actual %0d", $time, want.allocated,
                   got.allocated);
        if (got.live !== want.live)
          $display("%0t: live expected %0d actual %0d", $time, want.live, got.live);
        if (got.entries !== want.entries)
          $display("%0t: entries expected %0d actual %0d", $time, want.entries, got.entries);
        if (got !== want) errors++;
      end
    end
  end

  // Receiver stalls in bursts
  initial begin
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // Watchdog on handshake activity
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)
        || !rst_n)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    heap_reset();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_table_full();
    test_base_settings();
    test_random(250);
    drain();                               // sender waits for every result
    test_random(200);
    calm = 1'b1;
    test_random(100);
    release_all();
    drain();
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
